FILE: design/fabw_pkg.sv
`default_nettype none

package fabw_pkg;

   // Pixel and field widths
   localparam int PIX_W      = 32;
   localparam int COORD_W    = 12;
   localparam int FUNC_W     = 2;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   // Effective dimension (up to 4096) and the widest linear address (4096 * 4096)
   localparam int DIM_W      = 13;
   localparam int ADDR_MAX_W = 24;

   // Default frame bounds
   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;

   // Command queue between the front and the back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Function codes
   localparam logic [FUNC_W-1:0] FUNC_PLOT  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

   // Result status codes; the front also uses them to tag each queued item
   localparam logic [STATUS_W-1:0] ST_OPAQUE = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BLEND  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_SKIP   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_CLIP   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CLEAR  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_READ   = 3'd5;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FB_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FB_HEIGHT = 2'd1;

   localparam logic [CSR_DATA_W-1:0] DIM_RESET = 9'd256;

   // Classified item. For a clear, addr holds the last linear index to fill.
   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [ADDR_MAX_W-1:0] addr;
      logic [PIX_W-1:0]      color;
   } op_type;

   // Exact floor(v / 255) for any v up to 255*255
   function automatic logic [7:0] div255(input logic [15:0] v);
      logic [16:0] t;
      begin
         t = {1'b0, v} + {9'd0, v[15:8]} + 17'd1;
         return t[15:8];
      end
   endfunction

endpackage

`default_nettype wire

FILE: design/fabw_front.sv
`default_nettype none

module fabw_front #(
   parameter int MAX_WIDTH  = fabw_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = fabw_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [fabw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [fabw_pkg::CSR_DATA_W-1:0]     csr_data,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [fabw_pkg::FUNC_W-1:0]         req_func,
   input  wire logic signed [fabw_pkg::COORD_W-1:0] req_x_pos,
   input  wire logic signed [fabw_pkg::COORD_W-1:0] req_y_pos,
   input  wire logic [fabw_pkg::PIX_W-1:0]          req_color,
   input  wire logic                                init_done,
   input  wire logic                                push_ready,
   output logic                                     push_valid,
   output fabw_pkg::op_type                         push_op
);
   import fabw_pkg::*;

   logic [CSR_DATA_W-1:0]  fb_width_ff, fb_width_in;
   logic [CSR_DATA_W-1:0]  fb_height_ff, fb_height_in;
   logic [ADDR_MAX_W-1:0]  clear_last;
   logic [DIM_W-1:0]       w_eff, h_eff;
   logic [2*DIM_W-1:0]     area;
   logic [COORD_W-2:0]     x_lo, y_lo;
   logic                   in_frame;
   logic [ADDR_MAX_W-1:0]  row_base;
   logic [7:0]             alpha;

   assign csr_ready = 1'b1;

   // Size registers
   always_comb begin
      fb_width_in  = fb_width_ff;
      fb_height_in = fb_height_ff;
      if (csr_valid) begin
         if (csr_index == CSR_FB_WIDTH)  fb_width_in  = csr_data;
         if (csr_index == CSR_FB_HEIGHT) fb_height_in = csr_data;
      end
   end

   // Saturate sizes to [1, max]
   always_comb begin
      if (fb_width_ff == '0)
         w_eff = DIM_W'(1);
      else if ({{(DIM_W-CSR_DATA_W){1'b0}}, fb_width_ff} > DIM_W'(MAX_WIDTH))
         w_eff = DIM_W'(MAX_WIDTH);
      else
         w_eff = {{(DIM_W-CSR_DATA_W){1'b0}}, fb_width_ff};

      if (fb_height_ff == '0)
         h_eff = DIM_W'(1);
      else if ({{(DIM_W-CSR_DATA_W){1'b0}}, fb_height_ff} > DIM_W'(MAX_HEIGHT))
         h_eff = DIM_W'(MAX_HEIGHT);
      else
         h_eff = {{(DIM_W-CSR_DATA_W){1'b0}}, fb_height_ff};
   end

   // Last index of a clear sweep, from the current sizes
   assign area       = w_eff * h_eff;
   assign clear_last = ADDR_MAX_W'(area - 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_width_ff  <= DIM_RESET;
         fb_height_ff <= DIM_RESET;
      end else begin
         fb_width_ff  <= fb_width_in;
         fb_height_ff <= fb_height_in;
      end
   end

   // Clip test and linear address
   assign x_lo     = req_x_pos[COORD_W-2:0];
   assign y_lo     = req_y_pos[COORD_W-2:0];
   assign in_frame = !req_x_pos[COORD_W-1] && !req_y_pos[COORD_W-1]
                     && ({{(DIM_W-COORD_W+1){1'b0}}, x_lo} < w_eff)
                     && ({{(DIM_W-COORD_W+1){1'b0}}, y_lo} < h_eff);
   assign row_base = ADDR_MAX_W'(y_lo) * ADDR_MAX_W'(w_eff);
   assign alpha    = req_color[7:0];

   // Classify the item
   always_comb begin
      push_op.color  = req_color;
      push_op.addr   = row_base + ADDR_MAX_W'(x_lo);
      push_op.status = ST_CLIP;
      unique case (req_func)
         FUNC_PLOT: begin
            if (!in_frame)           push_op.status = ST_CLIP;
            else if (alpha == 8'hFF) push_op.status = ST_OPAQUE;
            else if (alpha != 8'h00) push_op.status = ST_BLEND;
            else                     push_op.status = ST_SKIP;
         end
         FUNC_READ: begin
            push_op.status = in_frame ? ST_READ : ST_CLIP;
         end
         FUNC_CLEAR: begin
            push_op.status = ST_CLEAR;
            push_op.addr   = clear_last;
         end
         default: begin
            push_op.status = ST_CLIP;
         end
      endcase
   end

   assign req_ready  = push_ready && init_done;
   assign push_valid = req_valid && req_ready;

endmodule

`default_nettype wire

FILE: design/fabw_queue.sv
`default_nettype none

module fabw_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   input  wire fabw_pkg::op_type push_op,
   output logic                  push_ready,
   output logic                  pop_valid,
   output fabw_pkg::op_type      pop_op,
   input  wire logic             pop
);
   import fabw_pkg::*;

   op_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = count_ff != (QPTR_W+1)'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_op     = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   // Pointer and fill tracking
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) entry_ff[wr_ptr_ff] <= push_op;
   end

endmodule

`default_nettype wire

FILE: design/fabw_back.sv
`default_nettype none

module fabw_back #(
   parameter int MAX_WIDTH  = fabw_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = fabw_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              q_valid,
   input  wire fabw_pkg::op_type                  q_op,
   output logic                                   q_pop,
   output logic                                   init_done,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [fabw_pkg::STATUS_W-1:0]          rsp_status,
   output logic [fabw_pkg::PIX_W-1:0]             rsp_pixel_value
);
   import fabw_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // Sequencer states
   localparam logic [2:0] S_INIT = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_RD   = 3'd2;
   localparam logic [2:0] S_MIX  = 3'd3;
   localparam logic [2:0] S_CLR  = 3'd4;
   localparam logic [2:0] S_FIN  = 3'd5;

   logic [PIX_W-1:0]    mem [DEPTH];
   logic [PIX_W-1:0]    mem_rd_ff;
   logic                mem_we;
   logic [AW-1:0]       mem_addr;
   logic [PIX_W-1:0]    mem_wdata;

   logic [2:0]          state_ff, state_in;
   op_type              op_ff, op_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic [15:0]         sum_ff [3];
   logic [15:0]         sum_in [3];
   logic [PIX_W-1:0]    res_ff, res_in;
   logic [PIX_W-1:0]    blended;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [PIX_W-1:0]    rsp_pixel_ff, rsp_pixel_in;
   logic                out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign init_done = state_ff != S_INIT;
   assign q_pop     = (state_ff == S_IDLE) && q_valid;

   // Per-channel source-over products from the registered destination pixel
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sum_in[c] = {8'd0, op_ff.color[8*c+8 +: 8]} * {8'd0, op_ff.color[7:0]}
                   + {8'd0, mem_rd_ff[8*c+8 +: 8]} * {8'd0, 8'hFF - op_ff.color[7:0]};
      end
   end

   assign blended = {div255(sum_ff[2]), div255(sum_ff[1]), div255(sum_ff[0]), 8'hFF};

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_pixel_in  = rsp_pixel_ff;
      mem_we        = 1'b0;
      mem_addr      = idx_ff;
      mem_wdata     = op_ff.color;
      unique case (state_ff)
         S_INIT: begin
            mem_we    = 1'b1;
            mem_wdata = '0;
            idx_in    = idx_ff + 1'b1;
            if (idx_ff == AW'(DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            mem_addr = q_op.addr[AW-1:0];
            if (q_valid) begin
               op_in  = q_op;
               idx_in = '0;
               priority case (q_op.status)
                  ST_OPAQUE: begin
                     mem_we    = 1'b1;
                     mem_wdata = q_op.color;
                     res_in    = q_op.color;
                     state_in  = S_FIN;
                  end
                  ST_BLEND, ST_SKIP, ST_READ: begin
                     state_in = S_RD;
                  end
                  ST_CLEAR: begin
                     state_in = S_CLR;
                  end
                  default: begin
                     res_in   = '0;
                     state_in = S_FIN;
                  end
               endcase
            end
         end
         S_RD: begin
            res_in   = mem_rd_ff;
            state_in = (op_ff.status == ST_BLEND) ? S_MIX : S_FIN;
         end
         S_MIX: begin
            mem_we    = 1'b1;
            mem_addr  = op_ff.addr[AW-1:0];
            mem_wdata = blended;
            res_in    = blended;
            state_in  = S_FIN;
         end
         S_CLR: begin
            mem_we = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == op_ff.addr[AW-1:0]) begin
               res_in   = op_ff.color;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = op_ff.status;
               rsp_pixel_in  = res_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      res_ff        <= res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pixel_ff  <= rsp_pixel_in;
      for (int c = 0; c < 3; c++) sum_ff[c] <= sum_in[c];
   end

   // Pixel store: one port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      mem_rd_ff <= mem[mem_addr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_pixel_value = rsp_pixel_ff;

endmodule

`default_nettype wire

FILE: design/framebuffer_alpha_blend_writer.sv
`default_nettype none

// Channel   Ports                                          Direction
// -------   --------------------------------------------   ---------
// request   req_valid/ready, func, x_pos, y_pos, color     in
// result    rsp_valid/ready, status, pixel_value           out
// config    csr_valid/ready, csr_index, csr_data           in
//
// The back end runs one item at a time on the single-port pixel store: clip and
// opaque plot pass IDLE then FIN, read and transparent skip add RD, blend adds
// RD and MIX, and clear sweeps W*H indexes in CLR. After reset the store is swept
// to zero over MAX_WIDTH*MAX_HEIGHT entries (65536 by default) with req_ready
// low; config writes are taken meanwhile. A two-item queue lets requests be
// accepted while the back end works or while a result waits in the output register for rsp_ready.

module framebuffer_alpha_blend_writer #(
   parameter int MAX_WIDTH  = fabw_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = fabw_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [fabw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [fabw_pkg::CSR_DATA_W-1:0]     csr_data,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [fabw_pkg::FUNC_W-1:0]         req_func,
   input  wire logic signed [fabw_pkg::COORD_W-1:0] req_x_pos,
   input  wire logic signed [fabw_pkg::COORD_W-1:0] req_y_pos,
   input  wire logic [fabw_pkg::PIX_W-1:0]          req_color,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [fabw_pkg::STATUS_W-1:0]            rsp_status,
   output logic [fabw_pkg::PIX_W-1:0]               rsp_pixel_value
);
   import fabw_pkg::*;

   logic   init_done;
   logic   push_valid, push_ready;
   op_type push_op;
   logic   q_valid, q_pop;
   op_type q_op;

   fabw_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_func   (req_func),
      .req_x_pos  (req_x_pos),
      .req_y_pos  (req_y_pos),
      .req_color  (req_color),
      .init_done  (init_done),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_op    (push_op)
   );

   fabw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_op    (push_op),
      .push_ready (push_ready),
      .pop_valid  (q_valid),
      .pop_op     (q_op),
      .pop        (q_pop)
   );

   fabw_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_op            (q_op),
      .q_pop           (q_pop),
      .init_done       (init_done),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_pixel_value (rsp_pixel_value)
   );

   // Only defined status codes leave the block
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_READ))
      else $error("undefined result status");

   // Clipped items carry a zero pixel
   a_clip_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_CLIP) |-> (rsp_pixel_value == '0))
      else $error("clipped result with nonzero pixel");

   // Written plot pixels are always fully opaque
   a_plot_opaque: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_OPAQUE || rsp_status == ST_BLEND))
         |-> (rsp_pixel_value[7:0] == 8'hFF))
      else $error("plotted pixel without full alpha");

   // No item is taken before the store sweep has finished
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> init_done && push_valid)
      else $error("item accepted during store sweep");

endmodule

`default_nettype wire
